>>> hw/rtl/pidsa_pkg.sv
package pidsa_pkg;

  // List geometry. The port fields are fixed at 5 bits, so the depth is fixed too.
  localparam int DEPTH = 16;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int VAL_W = 32;
  localparam int POS_W = 5;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_SEARCH = 2'd2,
    OP_READ   = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    opcode_t            opcode;
    logic [POS_W-1:0]   position;
    logic signed [31:0] value;
  } in_t;

  typedef struct packed {
    status_t            status;
    logic               found;
    logic signed [31:0] read_value;
    logic [4:0]         entry_count;
  } out_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_MOVE_RD,
    S_MOVE_WR,
    S_PUT,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_FETCH,
    S_FINISH
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic cap;      // latch request, run bounds check
    logic rd_move;  // read neighbor of idx for a shift
    logic wr_move;  // write shifted entry at idx, step idx
    logic wr_put;   // write insert value at idx
    logic rd_idx;   // read entry at idx
    logic cmp;      // compare read data with search value, step idx
    logic finish;   // update count, load result register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    opcode_t op;
    logic    err;
    logic    last;
  } stat_t;

endpackage

>>> hw/rtl/positional_insert_delete_search_array.sv
// Positional insert / delete / search / read list of up to 16 signed 32-bit values.
//
// Input channel (in_valid / in_ready / in_data): one request per transaction,
// carrying opcode, 1-based position and value. Output channel (out_valid /
// out_ready / out_data): exactly one result transaction per request, in order.
//
// One request is worked at a time; in_ready is high only while idle. Entries
// live in a single-port-read, single-port-write RAM, so each shifted or
// scanned entry goes through a bounds step, a read, then a write or compare.
// The result sits in an output register; if the receiver stalls, the next
// request can be accepted and worked, and it waits in its final step until the
// register is free. Reset (rst_n low, synchronous) empties the list and drops
// any pending result; RAM contents are left as they are.
module positional_insert_delete_search_array
  import pidsa_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  cmd_t  cmd;
  stat_t stat;

  // sequencer: walks one entry at a time, owns the handshakes
  pidsa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // storage, count, bounds check and result register
  pidsa_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .stat     (stat),
    .out_data (out_data)
  );

  // only one request in flight
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while another is in flight");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.entry_count <= 5'(DEPTH))
    else $error("entry count above depth");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == ST_FULL |-> out_data.entry_count == 5'(DEPTH))
    else $error("full status with list not full");

  a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.found |-> out_data.status == ST_OK && out_data.read_value == '0)
    else $error("found flag with bad status or read data");

endmodule

>>> hw/rtl/pidsa_ctrl.sv
module pidsa_ctrl
  import pidsa_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  output logic  out_valid,
  input  logic  out_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (stat.err) begin
          state_nxt = S_FINISH;
        end else begin
          case (stat.op)
            OP_INSERT: state_nxt = stat.last ? S_PUT : S_MOVE_RD;
            OP_DELETE: state_nxt = stat.last ? S_FINISH : S_MOVE_RD;
            OP_SEARCH: state_nxt = stat.last ? S_FINISH : S_SCAN_RD;
            default:   state_nxt = S_FETCH;
          endcase
        end
      end
      S_MOVE_RD:  state_nxt = S_MOVE_WR;
      S_MOVE_WR:  state_nxt = S_CHECK;
      S_PUT:      state_nxt = S_FINISH;
      S_SCAN_RD:  state_nxt = S_SCAN_CMP;
      S_SCAN_CMP: state_nxt = S_CHECK;
      S_FETCH:    state_nxt = S_FINISH;
      S_FINISH: begin
        if (slot_free) state_nxt = S_IDLE;
      end
      default:    state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd         = '0;
    cmd.cap     = (state_r == S_IDLE) && in_valid;
    cmd.rd_move = (state_r == S_MOVE_RD);
    cmd.wr_move = (state_r == S_MOVE_WR);
    cmd.wr_put  = (state_r == S_PUT);
    cmd.rd_idx  = (state_r == S_SCAN_RD) || (state_r == S_FETCH);
    cmd.cmp     = (state_r == S_SCAN_CMP);
    cmd.finish  = (state_r == S_FINISH) && slot_free;
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.finish) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

>>> hw/rtl/pidsa_dp.sv
module pidsa_dp
  import pidsa_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  in_t   in_data,
  input  cmd_t  cmd,
  output stat_t stat,
  output out_t  out_data
);

  logic [VAL_W-1:0] mem [DEPTH];

  opcode_t          op_r;
  logic [POS_W-1:0] pos_r;
  logic [VAL_W-1:0] val_r;
  status_t          status_r, status_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             found_r, found_nxt;
  logic [VAL_W-1:0] rdata_r;
  out_t             out_r, out_nxt;

  logic [CNT_W:0]   pos_x, cnt_x, idx_x;
  logic [IDX_W-1:0] raddr, waddr;
  logic [VAL_W-1:0] wdata;
  logic             rd_en, wr_en;

  // bounds check on the incoming request
  assign pos_x = (CNT_W + 1)'(in_data.position);
  assign cnt_x = {1'b0, count_r};
  assign idx_x = {1'b0, idx_r};

  always_comb begin
    status_nxt = ST_OK;
    idx_nxt    = idx_r;
    case (in_data.opcode)
      OP_INSERT: begin
        if (cnt_x >= (CNT_W + 1)'(DEPTH)) begin
          status_nxt = ST_FULL;
        end else if (pos_x == '0 || pos_x > cnt_x + 1'b1) begin
          status_nxt = ST_RANGE;
        end
        idx_nxt = count_r;
      end
      OP_SEARCH: begin
        idx_nxt = '0;
      end
      default: begin
        if (pos_x == '0 || pos_x > cnt_x) status_nxt = ST_RANGE;
        idx_nxt = CNT_W'(pos_x - 1'b1);
      end
    endcase
  end

  always_comb begin
    stat.op  = op_r;
    stat.err = (status_r != ST_OK);
    case (op_r)
      OP_INSERT: stat.last = (idx_x == (CNT_W + 1)'(pos_r) - 1'b1);
      OP_DELETE: stat.last = (idx_x + 1'b1 >= cnt_x);
      OP_SEARCH: stat.last = (idx_r >= count_r) || found_r;
      default:   stat.last = 1'b1;
    endcase
  end

  // memory port addressing
  always_comb begin
    rd_en = cmd.rd_move || cmd.rd_idx;
    raddr = idx_r[IDX_W-1:0];
    if (cmd.rd_move) begin
      raddr = (op_r == OP_INSERT) ? IDX_W'(idx_r - 1'b1) : IDX_W'(idx_r + 1'b1);
    end
    wr_en = cmd.wr_move || cmd.wr_put;
    waddr = idx_r[IDX_W-1:0];
    wdata = cmd.wr_put ? val_r : rdata_r;
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[waddr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rd_en) rdata_r <= mem[raddr];
  end

  always_comb begin
    found_nxt = found_r;
    if (cmd.cap) begin
      found_nxt = 1'b0;
    end else if (cmd.cmp && rdata_r == val_r) begin
      found_nxt = 1'b1;
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.finish && status_r == ST_OK) begin
      if (op_r == OP_INSERT) count_nxt = count_r + 1'b1;
      if (op_r == OP_DELETE) count_nxt = count_r - 1'b1;
    end
  end

  always_comb begin
    out_nxt             = out_r;
    out_nxt.status      = status_r;
    out_nxt.found       = (op_r == OP_SEARCH) && found_r;
    out_nxt.read_value  = (op_r == OP_READ && status_r == ST_OK) ? rdata_r : '0;
    out_nxt.entry_count = 5'(count_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    found_r <= found_nxt;
    if (cmd.cap) begin
      op_r     <= in_data.opcode;
      pos_r    <= in_data.position;
      val_r    <= in_data.value;
      status_r <= status_nxt;
      idx_r    <= idx_nxt;
    end else if (cmd.wr_move) begin
      idx_r <= (op_r == OP_INSERT) ? idx_r - 1'b1 : idx_r + 1'b1;
    end else if (cmd.cmp) begin
      idx_r <= idx_r + 1'b1;
    end
    if (cmd.finish) out_r <= out_nxt;
  end

  assign out_data = out_r;

endmodule
